### rtl/cbps_pkg.sv
// Shared constants and types for the cubic Bezier path sampler.
`timescale 1ns / 1ps
package cbps_pkg;

    localparam int COORD_WIDTH_DEF  = 32;
    localparam int MAX_SEGMENTS_DEF = 63;

    // segments_per_curve register
    localparam int          CFG_W     = 6;
    localparam logic [5:0]  CFG_RESET = 6'd10;

    // t, u and Bernstein weights: unsigned Q1.16 with 1.0 = 65536
    localparam int           T_W   = 17;
    localparam logic [16:0]  T_ONE = 17'd65536;

    // 2^17 / (2N) sets the t step
    localparam int DIV_STEPS = 18;

    // control point selector: 0..2 held points, 3 the incoming point
    localparam logic [1:0] SEL_P0  = 2'd0;
    localparam logic [1:0] SEL_NEW = 2'd3;

    typedef struct packed {
        logic       run_end;
        logic [1:0] sel;
    } beat_tag_t;

endpackage

### rtl/cbps_pt_if.sv
// Waypoint and curve point channels.
`timescale 1ns / 1ps
interface cbps_pt_if #(parameter int CW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic                 last_point;
    modport source (output valid, point_x, point_y, point_z, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface cbps_cv_if #(parameter int CW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] curve_x;
    logic signed [CW-1:0] curve_y;
    logic signed [CW-1:0] curve_z;
    logic                 run_end;
    modport source (output valid, curve_x, curve_y, curve_z, run_end, input ready);
    modport sink   (input valid, curve_x, curve_y, curve_z, run_end, output ready);
endinterface

### rtl/cubic_bezier_path_sampler.sv
// Cubic Bezier path sampler top level: sequencer, weight pipeline, three lanes, output register.
// Waypoints enter one beat at a time. A point that is only stored issues no samples. A point
// that closes a cubic segment issues N+1 samples, one per cycle while the output is not
// stalled, into a six-stage pipeline (issue register, weights over three stages, lane
// products, output register); the next waypoint is taken once the issue register, weight
// stages and lane products have drained. A short-path or leftover end point issues one beat
// per emitted point and waits for the same drain. After reset and after each write of
// segments_per_curve, a serial divider computes the t step and no waypoint is taken
// meanwhile. The output register lets a stalled result wait without losing samples.
`timescale 1ns / 1ps
module cubic_bezier_path_sampler #(
    parameter int COORD_WIDTH  = cbps_pkg::COORD_WIDTH_DEF,
    parameter int MAX_SEGMENTS = cbps_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    cbps_pt_if.sink                    point,
    cbps_cv_if.source                  curve,
    input  logic                       cfg_we,
    input  logic [cbps_pkg::CFG_W-1:0] cfg_wdata
);
    import cbps_pkg::*;

    logic                          en;
    logic                          pipe_busy;
    logic                          issue_valid;
    logic [T_W-1:0]                issue_t;
    beat_tag_t                     issue_tag;
    logic signed [COORD_WIDTH-1:0] cp_x [4];
    logic signed [COORD_WIDTH-1:0] cp_y [4];
    logic signed [COORD_WIDTH-1:0] cp_z [4];
    logic [T_W-1:0]                w [4];
    logic signed [COORD_WIDTH-1:0] lx, ly, lz;

    // stages 1..3 weights, stage 4 lane products
    logic      v_reg   [4];
    beat_tag_t tag_reg [4];

    logic                          out_valid_reg;
    logic signed [COORD_WIDTH-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic                          out_end_reg;

    assign en        = !out_valid_reg || curve.ready;
    assign pipe_busy = issue_valid || v_reg[0] || v_reg[1] || v_reg[2] || v_reg[3];

    cbps_seq #(
        .COORD_WIDTH  (COORD_WIDTH),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .point       (point),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .en          (en),
        .pipe_busy   (pipe_busy),
        .issue_valid (issue_valid),
        .issue_t     (issue_t),
        .issue_tag   (issue_tag),
        .cp_x        (cp_x),
        .cp_y        (cp_y),
        .cp_z        (cp_z)
    );

    cbps_weight u_weight (
        .clk (clk),
        .en  (en),
        .t   (issue_t),
        .w   (w)
    );

    cbps_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_x (
        .clk (clk), .en (en), .w (w), .p (cp_x), .sel (tag_reg[2].sel), .coord (lx)
    );
    cbps_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_y (
        .clk (clk), .en (en), .w (w), .p (cp_y), .sel (tag_reg[2].sel), .coord (ly)
    );
    cbps_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_z (
        .clk (clk), .en (en), .w (w), .p (cp_z), .sel (tag_reg[2].sel), .coord (lz)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                v_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= issue_valid;
            for (int i = 1; i < 4; i++)
                v_reg[i] <= v_reg[i-1];
            out_valid_reg <= v_reg[3];
        end
    end

    // merge the three lanes into one result beat
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= issue_tag;
            for (int i = 1; i < 4; i++)
                tag_reg[i] <= tag_reg[i-1];
            out_x_reg   <= lx;
            out_y_reg   <= ly;
            out_z_reg   <= lz;
            out_end_reg <= tag_reg[3].run_end;
        end
    end

    assign curve.valid   = out_valid_reg;
    assign curve.curve_x = out_x_reg;
    assign curve.curve_y = out_y_reg;
    assign curve.curve_z = out_z_reg;
    assign curve.run_end = out_end_reg;

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        point.ready |-> !pipe_busy)
        else $error("waypoint taken while samples in flight");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg[3]) && $stable(tag_reg[3]))
        else $error("pipeline moved during output stall");
    a_end_valid: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[3] && en |=> out_valid_reg)
        else $error("lane result dropped");

endmodule

### rtl/cbps_seq.sv
// Segment sequencer: holds waypoints, computes the t step, issues sample beats.
`timescale 1ns / 1ps
module cbps_seq #(
    parameter int COORD_WIDTH  = cbps_pkg::COORD_WIDTH_DEF,
    parameter int MAX_SEGMENTS = cbps_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    cbps_pt_if.sink                       point,
    input  logic                          cfg_we,
    input  logic [cbps_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          en,
    input  logic                          pipe_busy,
    output logic                          issue_valid,
    output logic [cbps_pkg::T_W-1:0]      issue_t,
    output cbps_pkg::beat_tag_t           issue_tag,
    output logic signed [COORD_WIDTH-1:0] cp_x [4],
    output logic signed [COORD_WIDTH-1:0] cp_y [4],
    output logic signed [COORD_WIDTH-1:0] cp_z [4]
);
    import cbps_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;
    localparam logic [5:0] MAX_N = 6'(MAX_SEGMENTS);

    logic                          state_reg;
    logic [CFG_W-1:0]              cfg_reg;
    logic signed [COORD_WIDTH-1:0] held_x_reg [3];
    logic signed [COORD_WIDTH-1:0] held_y_reg [3];
    logic signed [COORD_WIDTH-1:0] held_z_reg [3];
    logic [1:0]                    hc_reg;
    logic                          any_reg;
    logic                          seg_reg;
    logic                          last_reg;
    logic [1:0]                    hc_snap_reg;
    logic [5:0]                    cnt_reg;
    logic [T_W-1:0]                q_reg;
    logic [6:0]                    r_reg;
    // divider for 2^17 / (2N)
    logic                          div_req_reg;
    logic [4:0]                    div_cnt_reg;
    logic [6:0]                    div_rem_reg;
    logic [T_W-1:0]                div_q_reg;
    logic                          iv_reg;
    logic [T_W-1:0]                it_reg;
    beat_tag_t                     itag_reg;

    logic [5:0]  n_eff;
    logic [6:0]  d2;
    logic [7:0]  div_sh;
    logic        div_bit;
    logic [7:0]  r_sum;
    logic        acc;
    logic [1:0]  pass_sel;
    logic        cnt_at_n;

    always_comb
    begin
        if (cfg_reg == '0)
            n_eff = 6'd1;
        else if (cfg_reg > MAX_N)
            n_eff = MAX_N;
        else
            n_eff = cfg_reg;
    end

    assign d2       = {n_eff, 1'b0};
    assign div_bit  = (div_cnt_reg == 5'(DIV_STEPS));
    assign div_sh   = {div_rem_reg, div_bit};
    assign r_sum    = {1'b0, r_reg} + {1'b0, div_rem_reg};
    assign cnt_at_n = (cnt_reg == n_eff);
    assign pass_sel = (cnt_reg == {4'b0, hc_snap_reg}) ? SEL_NEW : cnt_reg[1:0];

    assign point.ready = (state_reg == ST_IDLE) && !pipe_busy && !div_req_reg
                         && (div_cnt_reg == '0);
    assign acc = point.valid && point.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= CFG_RESET;
            div_req_reg <= 1'b1;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg     <= cfg_wdata;
                div_req_reg <= 1'b1;
            end
            else if (div_req_reg)
            begin
                div_req_reg <= 1'b0;
                div_cnt_reg <= 5'(DIV_STEPS);
            end
            else if (div_cnt_reg != '0)
                div_cnt_reg <= div_cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_req_reg && !cfg_we)
        begin
            div_rem_reg <= '0;
            div_q_reg   <= '0;
        end
        else if (div_cnt_reg != '0)
        begin
            if (div_sh >= {1'b0, d2})
            begin
                div_rem_reg <= 7'(div_sh - {1'b0, d2});
                div_q_reg   <= {div_q_reg[T_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= div_sh[6:0];
                div_q_reg   <= {div_q_reg[T_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hc_reg    <= '0;
            any_reg   <= 1'b0;
            iv_reg    <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                if (hc_reg == 2'd3)
                begin
                    state_reg <= ST_RUN;
                    hc_reg    <= point.last_point ? 2'd0 : 2'd1;
                    any_reg   <= !point.last_point;
                end
                else if (!point.last_point)
                    hc_reg <= hc_reg + 2'd1;
                else
                begin
                    state_reg <= ST_RUN;
                    hc_reg    <= '0;
                    any_reg   <= 1'b0;
                end
            end
            if (en)
            begin
                iv_reg <= (state_reg == ST_RUN);
                if (state_reg == ST_RUN)
                begin
                    if (seg_reg ? cnt_at_n : (pass_sel == SEL_NEW))
                        state_reg <= ST_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cp_x[i] <= held_x_reg[i];
                cp_y[i] <= held_y_reg[i];
                cp_z[i] <= held_z_reg[i];
            end
            cp_x[3]  <= point.point_x;
            cp_y[3]  <= point.point_y;
            cp_z[3]  <= point.point_z;
            last_reg <= point.last_point;
            cnt_reg  <= '0;
            q_reg    <= '0;
            r_reg    <= {1'b0, n_eff};
            if (hc_reg == 2'd3)
            begin
                seg_reg       <= 1'b1;
                held_x_reg[0] <= point.point_x;
                held_y_reg[0] <= point.point_y;
                held_z_reg[0] <= point.point_z;
            end
            else if (!point.last_point)
            begin
                held_x_reg[hc_reg] <= point.point_x;
                held_y_reg[hc_reg] <= point.point_y;
                held_z_reg[hc_reg] <= point.point_z;
            end
            else
            begin
                seg_reg     <= 1'b0;
                hc_snap_reg <= any_reg ? 2'd0 : hc_reg;
            end
        end
        else if (en && state_reg == ST_RUN)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (seg_reg)
            begin
                it_reg           <= q_reg;
                itag_reg.sel     <= SEL_P0;
                itag_reg.run_end <= last_reg && cnt_at_n;
                // t advances by 2^17/(2N); remainder carries into the next step
                if (r_sum >= {1'b0, d2})
                begin
                    r_reg <= 7'(r_sum - {1'b0, d2});
                    q_reg <= q_reg + div_q_reg + T_W'(1);
                end
                else
                begin
                    r_reg <= r_sum[6:0];
                    q_reg <= q_reg + div_q_reg;
                end
            end
            else
            begin
                // pass-through: weights at t = 0 reproduce the point that sel routes into the P0 slot exactly
                it_reg           <= '0;
                itag_reg.sel     <= pass_sel;
                itag_reg.run_end <= (pass_sel == SEL_NEW);
            end
        end
    end

    assign issue_valid = iv_reg;
    assign issue_t     = it_reg;
    assign issue_tag   = itag_reg;

    a_seg_runs: assert property (@(posedge clk) disable iff (!rst_n)
        acc && hc_reg == 2'd3 |=> state_reg == ST_RUN)
        else $error("segment close did not start a run");
    a_cfg_div: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> div_req_reg && !point.ready)
        else $error("config write did not restart the step divider");
    a_run_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> div_cnt_reg == '0 && !div_req_reg)
        else $error("run started while step divider busy");

endmodule

### rtl/cbps_weight.sv
// Bernstein weight pipeline: t -> w0..w3 over three registered stages.
`timescale 1ns / 1ps
module cbps_weight (
    input  logic                     clk,
    input  logic                     en,
    input  logic [cbps_pkg::T_W-1:0] t,
    output logic [cbps_pkg::T_W-1:0] w [4]
);
    import cbps_pkg::*;

    localparam int SQ_W = 2 * T_W;
    localparam int CU_W = 3 * T_W;
    localparam int R_W  = CU_W + 2;
    localparam logic [R_W-1:0] HALF = R_W'(1) << 31;

    logic [T_W-1:0]  t1_reg, u1_reg;
    logic [SQ_W-1:0] uu_reg, tt_reg;
    logic [CU_W-1:0] a_reg [4];
    logic [T_W-1:0]  u0;

    assign u0 = T_ONE - t;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= t;
            u1_reg <= u0;
            uu_reg <= SQ_W'(u0) * SQ_W'(u0);
            tt_reg <= SQ_W'(t) * SQ_W'(t);

            a_reg[0] <= CU_W'(uu_reg) * CU_W'(u1_reg);
            a_reg[1] <= CU_W'(uu_reg) * CU_W'(t1_reg);
            a_reg[2] <= CU_W'(tt_reg) * CU_W'(u1_reg);
            a_reg[3] <= CU_W'(tt_reg) * CU_W'(t1_reg);

            w[0] <= T_W'((R_W'(a_reg[0]) + HALF) >> 32);
            w[1] <= T_W'((R_W'(a_reg[1]) + (R_W'(a_reg[1]) << 1) + HALF) >> 32);
            w[2] <= T_W'((R_W'(a_reg[2]) + (R_W'(a_reg[2]) << 1) + HALF) >> 32);
            w[3] <= T_W'((R_W'(a_reg[3]) + HALF) >> 32);
        end
    end

endmodule

### rtl/cbps_lane.sv
// One coordinate lane: weighted sum of four control points, rounded and saturated.
`timescale 1ns / 1ps
module cbps_lane #(
    parameter int COORD_WIDTH = cbps_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [cbps_pkg::T_W-1:0]      w [4],
    input  logic signed [COORD_WIDTH-1:0] p [4],
    input  logic [1:0]                    sel,
    output logic signed [COORD_WIDTH-1:0] coord
);
    import cbps_pkg::*;

    localparam int PW = COORD_WIDTH + T_W + 1;
    localparam int SW = PW + 2;
    localparam int RW = SW - 16;

    logic signed [PW-1:0] prod_reg [4];
    logic signed [SW-1:0] sum;
    logic signed [RW-1:0] rs;
    logic signed [PW-1:0] p0;

    assign p0 = PW'(p[sel]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= PW'(signed'({1'b0, w[0]})) * p0;
            for (int i = 1; i < 4; i++)
                prod_reg[i] <= PW'(signed'({1'b0, w[i]})) * PW'(p[i]);
        end
    end

    // round half up, then arithmetic shift by 16
    assign sum = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2])
                 + SW'(prod_reg[3]) + SW'(32768);
    assign rs  = RW'(sum >>> 16);

    always_comb
    begin
        if (rs[RW-1:COORD_WIDTH-1] == '0 || rs[RW-1:COORD_WIDTH-1] == '1)
            coord = rs[COORD_WIDTH-1:0];
        else if (rs[RW-1])
            coord = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        else
            coord = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end

endmodule

### dv/cbps_checker.sv
// Checker for the cubic Bezier path sampler: predicts curve beats and compares them.
`timescale 1ns / 1ps
module cbps_checker (
    input  logic          clk,
    input  logic          rst_n,
    cbps_pt_if.sink       point,
    cbps_cv_if.sink       curve,
    input  logic          cfg_we,
    input  logic [cbps_pkg::CFG_W-1:0] cfg_wdata,
    output int            fail_count,
    output int            pending
);
    import cbps_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
    } curve_pt_t;

    curve_pt_t         expected_q[$];
    logic [CFG_W-1:0]  seg_n;
    longint            held_x[3], held_y[3], held_z[3];
    int                held_cnt;
    bit                seg_done;

    assign pending = expected_q.size();

    function automatic longint mix(longint w[4], longint p[4]);
        longint hi_sum;
        longint lo_sum;
        longint lo;
        longint r;
        hi_sum = 0;
        lo_sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            lo = p[i] & 64'hFFFF;
            hi_sum += w[i] * ((p[i] - lo) >>> 16);
            lo_sum += w[i] * lo;
        end
        r = hi_sum + ((lo_sum + 32768) >>> 16);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r;
    endfunction

    function automatic void push_pt(longint x, longint y, longint z, bit last);
        curve_pt_t c;
        c.x = x[31:0];
        c.y = y[31:0];
        c.z = z[31:0];
        c.last = last;
        expected_q.push_back(c);
    endfunction

    function automatic void sample_segment(longint x3, longint y3, longint z3, bit last);
        longint n, t, u;
        longint w[4], px[4], py[4], pz[4];
        n = seg_n;
        if (n == 0)
            n = 1;
        if (n > MAX_SEGMENTS_DEF)
            n = MAX_SEGMENTS_DEF;
        for (int i = 0; i < 3; i++)
        begin
            px[i] = held_x[i];
            py[i] = held_y[i];
            pz[i] = held_z[i];
        end
        px[3] = x3;
        py[3] = y3;
        pz[3] = z3;
        for (longint j = 0; j <= n; j++)
        begin
            t = (j * 131072 + n) / (2 * n);
            u = 65536 - t;
            // u^3 fits in 49 bits, 3u^2t fits comfortably in 64
            w[0] = (u * u * u + 64'h80000000) >>> 32;
            w[1] = (3 * u * u * t + 64'h80000000) >>> 32;
            w[2] = (3 * u * t * t + 64'h80000000) >>> 32;
            w[3] = (t * t * t + 64'h80000000) >>> 32;
            push_pt(mix(w, px), mix(w, py), mix(w, pz), last && j == n);
        end
    endfunction

    function automatic void take_point(longint x, longint y, longint z, bit last);
        if (held_cnt >= 3)
        begin
            sample_segment(x, y, z, last);
            held_x[0] = x;
            held_y[0] = y;
            held_z[0] = z;
            held_cnt = 1;
            seg_done = 1;
        end
        else if (!last)
        begin
            held_x[held_cnt] = x;
            held_y[held_cnt] = y;
            held_z[held_cnt] = z;
            held_cnt++;
        end
        else
        begin
            if (!seg_done)
                for (int i = 0; i < held_cnt; i++)
                    push_pt(held_x[i], held_y[i], held_z[i], 0);
            push_pt(x, y, z, 1);
        end
        if (last)
        begin
            held_cnt = 0;
            seg_done = 0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        curve_pt_t e;
        if (!rst_n)
        begin
            seg_n = CFG_RESET;
            held_cnt = 0;
            seg_done = 0;
            fail_count = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
                seg_n = cfg_wdata;
            if (curve.valid && curve.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected curve beat x=%0d", curve.curve_x);
                    fail_count++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (curve.curve_x !== e.x)
                    begin
                        $error("curve_x expected %0d actual %0d", e.x, curve.curve_x);
                        fail_count++;
                    end
                    if (curve.curve_y !== e.y)
                    begin
                        $error("curve_y expected %0d actual %0d", e.y, curve.curve_y);
                        fail_count++;
                    end
                    if (curve.curve_z !== e.z)
                    begin
                        $error("curve_z expected %0d actual %0d", e.z, curve.curve_z);
                        fail_count++;
                    end
                    if (curve.run_end !== e.last)
                    begin
                        $error("run_end expected %0d actual %0d", e.last, curve.run_end);
                        fail_count++;
                    end
                end
            end
            if (point.valid && point.ready)
                take_point(longint'(point.point_x), longint'(point.point_y),
                           longint'(point.point_z), point.last_point);
        end
    end
endmodule

### dv/tb.sv
// Testbench top for the cubic Bezier path sampler: stimulus, reset and verdict.
`timescale 1ns / 1ps
module tb;
    import cbps_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic             curve_ready;
    int               fail_count;
    int               pending;
    int               cycle_cnt;
    bit               busy_mode;   // false during the stretch without idling

    cbps_pt_if #(32) pt ();
    cbps_cv_if #(32) cv ();

    cubic_bezier_path_sampler u_dut (
        .clk(clk), .rst_n(rst_n), .point(pt.sink), .curve(cv.source),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    cbps_checker u_chk (
        .clk(clk), .rst_n(rst_n), .point(pt.sink), .curve(cv.sink),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    assign cv.ready = curve_ready;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 400000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
        curve_ready <= busy_mode ? ($urandom_range(99) >= 24) : 1'b1;

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(2047) - 1024;
            default: return $urandom;
        endcase
    endfunction

    // valid stays high after the beat; the next call or the caller drops it
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last);
        while (busy_mode && $urandom_range(99) < 24)
        begin
            pt.valid <= 0;
            @(negedge clk);
        end
        pt.valid <= 1;
        pt.point_x <= x;
        pt.point_y <= y;
        pt.point_z <= z;
        pt.last_point <= last;
        @(posedge clk);
        while (!pt.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_path(int len);
        for (int i = 0; i < len; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
    endtask

    task automatic write_n(logic [CFG_W-1:0] n);
        pt.valid <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        cfg_we <= 1;
        cfg_wdata <= n;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    initial
    begin
        int sent;
        int len;
        rst_n = 0;
        cycle_cnt = 0;
        busy_mode = 1;
        cfg_we = 0;
        cfg_wdata = 0;
        curve_ready = 1;
        pt.valid = 0;
        pt.point_x = 0;
        pt.point_y = 0;
        pt.point_z = 0;
        pt.last_point = 0;
        repeat (4) @(negedge clk);
        rst_n = 1;

        // short paths of one, two and three points at default N
        send_point(32'h7FFFFFFF, 32'h80000000, 0, 1);
        send_path(2);
        send_path(3);
        // full extremes on one segment, last point closes it
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 0);
        send_point(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 0);
        send_point(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 0);
        send_point(32'h80000000, 32'h7FFFFFFF, 32'h00000001, 1);
        // leftover points after a segment
        send_path(6);
        write_n(0);
        send_path(4);
        write_n(63);
        send_path(7);
        write_n(1);
        send_path(5);

        sent = 32;
        while (sent < 110)
        begin
            if (sent > 50 && sent < 75)
                busy_mode = 0;
            else
                busy_mode = 1;
            if ($urandom_range(9) == 0)
                write_n(($urandom_range(3) == 0) ? CFG_W'($urandom_range(63))
                                                 : CFG_W'($urandom_range(12)));
            len = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 10);
            send_path(len);
            sent += len;
        end
        pt.valid <= 0;
        busy_mode = 1;

        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

### cubic_bezier_path_sampler.f
rtl/cbps_pkg.sv
rtl/cbps_pt_if.sv
rtl/cbps_seq.sv
rtl/cbps_weight.sv
rtl/cbps_lane.sv
rtl/cubic_bezier_path_sampler.sv
dv/cbps_checker.sv
dv/tb.sv
